// ===== rtl/core/mpzc_pkg.sv =====
// Package for the mono page to RGB565 zone colour block.
// Holds beat structs, config register indexes and zone colour constants; no dependencies.
package mpzc_pkg;

    localparam int ROWS_PER_PAGE = 8;
    localparam int BIT_IDX_W     = 3;
    localparam int ROW_W         = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [ROW_W-1:0] FRAME_TOP    = 6'd37;
    localparam logic [ROW_W-1:0] FRAME_BOTTOM = 6'd48;
    localparam logic [ROW_W-1:0] LINE_TOP     = 6'd62;
    localparam logic [6:0]       LOGO_WIDTH   = 7'd47;
    localparam logic [6:0]       BAR_LEFT     = 7'd37;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THEME_SELECT = 3'd0,
        CFG_BACKGROUND   = 3'd1,
        CFG_UI           = 3'd2,
        CFG_KILL_FORE    = 3'd3,
        CFG_KILL_BACK    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        THEME_STATUS = 2'd0,
        THEME_KILL   = 2'd1,
        THEME_BOOT_A = 2'd2,
        THEME_BOOT_B = 2'd3
    } t_theme;

    typedef struct packed {
        logic [6:0] column_index;
        logic [2:0] page_row;
        logic [7:0] page_bits;
    } t_in_beat;

    typedef struct packed {
        logic [8:0]  dest_x;
        logic [7:0]  dest_y;
        logic [15:0] pixel_colour;
        logic        last_of_byte;
    } t_out_beat;

    typedef struct packed {
        t_theme      theme_select;
        logic [15:0] background_colour;
        logic [15:0] ui_colour;
        logic [15:0] kill_fore_colour;
        logic [15:0] kill_back_colour;
    } t_cfg;

    function automatic logic [15:0] to565(input logic [23:0] rgb);
        to565 = {rgb[23:19], rgb[15:10], rgb[7:3]};
    endfunction

    localparam logic [15:0] COL_LOGO   = to565(24'h75aec4);
    localparam logic [15:0] COL_DARK   = to565(24'h001b33);
    localparam logic [15:0] COL_PALE   = to565(24'hbaffec);
    localparam logic [15:0] COL_YELLOW = to565(24'hedff72);

endpackage

// ===== rtl/core/mpzc_cfg.sv =====
// Configuration register file for the zone colour block.
// Depends on mpzc_pkg for register indexes and the t_cfg struct.
module mpzc_cfg
    import mpzc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.theme_select      <= THEME_STATUS;
            r_cfg.background_colour <= 16'h0000;
            r_cfg.ui_colour         <= 16'hFFFF;
            r_cfg.kill_fore_colour  <= 16'hFFE0;
            r_cfg.kill_back_colour  <= 16'hF800;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THEME_SELECT: r_cfg.theme_select      <= t_theme'(i_cfg_data[1:0]);
                CFG_BACKGROUND:   r_cfg.background_colour <= i_cfg_data;
                CFG_UI:           r_cfg.ui_colour         <= i_cfg_data;
                CFG_KILL_FORE:    r_cfg.kill_fore_colour  <= i_cfg_data;
                CFG_KILL_BACK:    r_cfg.kill_back_colour  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/mpzc_colour.sv =====
// Colour selection for one source pixel: theme, zone lookup and lit bit.
// Depends on mpzc_pkg for the t_cfg struct and zone constants.
module mpzc_colour
    import mpzc_pkg::*;
(
    input  t_cfg             i_cfg,
    input  logic [6:0]       i_col,
    input  logic [ROW_W-1:0] i_row,
    input  logic             i_lit,
    output logic [15:0]      o_colour
);

    logic [15:0] zone_fore;
    logic [15:0] fore;
    logic [15:0] back;

    always_comb begin
        if (i_row < FRAME_TOP) begin
            zone_fore = (i_col < LOGO_WIDTH) ? COL_LOGO : COL_DARK;
        end else if (i_row < FRAME_BOTTOM) begin
            zone_fore = COL_PALE;
        end else if (i_row < LINE_TOP) begin
            zone_fore = (i_col < BAR_LEFT) ? COL_DARK : COL_YELLOW;
        end else begin
            zone_fore = COL_PALE;
        end
    end

    always_comb begin
        case (i_cfg.theme_select)
            THEME_KILL: begin
                fore = i_cfg.kill_fore_colour;
                back = i_cfg.kill_back_colour;
            end
            THEME_BOOT_A, THEME_BOOT_B: begin
                fore = COL_DARK;
                back = i_cfg.background_colour;
            end
            default: begin
                fore = zone_fore;
                back = i_cfg.background_colour;
            end
        endcase
    end

    assign o_colour = i_lit ? fore : back;

endmodule

// ===== rtl/core/mono_page_to_rgb565_zone_colour.sv =====
// Mono page byte to RGB565 3x3 block stream, top level.
// Each byte is held in the input register; its beats load the output register in turn,
// one beat per cycle while i_out_stall is low, as the bit counter steps the held byte.
// The next byte is taken on the cycle the eighth beat loads the output register.
// Reset: synchronous active low; clears control state and config to defaults.
module mono_page_to_rgb565_zone_colour
    import mpzc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                 cfg;
    t_in_beat             r_in;
    logic                 r_busy;
    logic [BIT_IDX_W-1:0] r_n;
    logic                 r_out_valid;
    t_out_beat            r_out;
    t_out_beat            n_out;
    logic                 adv;
    logic                 take;
    logic                 last;
    logic                 in_acc;
    logic [ROW_W-1:0]     row;
    logic [15:0]          colour;

    mpzc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign row = {r_in.page_row, r_n};

    mpzc_colour u_colour (
        .i_cfg    (cfg),
        .i_col    (r_in.column_index),
        .i_row    (row),
        .i_lit    (r_in.page_bits[r_n]),
        .o_colour (colour)
    );

    assign adv        = !r_out_valid || !i_out_stall;
    assign take       = r_busy && adv;
    assign last       = (r_n == BIT_IDX_W'(ROWS_PER_PAGE - 1));
    assign o_in_stall = r_busy && !(take && last);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_out.dest_x       = {1'b0, r_in.column_index, 1'b0} + {2'b00, r_in.column_index};
        n_out.dest_y       = {1'b0, row, 1'b0} + {2'b00, row};
        n_out.pixel_colour = colour;
        n_out.last_of_byte = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (take && last) begin
                r_busy <= 1'b0;
            end
            if (in_acc) begin
                r_n <= '0;
            end else if (take) begin
                r_n <= r_n + 1'b1;
            end
            if (adv) begin
                r_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_accept_starts_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_busy && (r_n == '0))
        else $error("accepted byte did not start at bit zero");

    a_idle_counter_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_n == '0))
        else $error("bit counter nonzero while idle");

    a_last_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && last |=> r_out_valid && r_out.last_of_byte)
        else $error("eighth beat not flagged as last");

    a_mid_byte_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.last_of_byte |-> r_busy)
        else $error("byte released before its last beat");

endmodule
